@@ hdl/kppc_pkg.sv @@
// Shared types and constants for the knob pickup parameter controller.
`timescale 1ns / 1ps
package kppc_pkg;

  localparam int KPPC_DEBOUNCE_DEPTH = 4;
  localparam int SAMPLE_W = 10;
  localparam int INDEX_W = 3;
  localparam logic [INDEX_W-1:0] CONTROL_LAST = 3'd5;

  typedef enum logic [1:0] {
    CMD_KNOB = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_LOCK = 2'd2,
    CMD_FREQ = 2'd3
  } command_t;

  localparam logic [INDEX_W-1:0] CTRL_TUNING = 3'd0;
  localparam logic [INDEX_W-1:0] CTRL_OSC_WAVE = 3'd1;
  localparam logic [INDEX_W-1:0] CTRL_LFO_WAVE = 3'd2;
  localparam logic [INDEX_W-1:0] CTRL_LFO_RATE = 3'd3;
  localparam logic [INDEX_W-1:0] CTRL_ATTACK = 3'd4;
  localparam logic [INDEX_W-1:0] CTRL_DECAY = 3'd5;

  typedef struct packed {
    logic [INDEX_W-1:0] selected_control;
    logic               is_locked;
    logic [6:0]         tuning_value;
    logic [1:0]         oscillator_wave;
    logic [1:0]         lfo_wave;
    logic [6:0]         lfo_rate;
    logic [10:0]        attack_time;
    logic [10:0]        decay_time;
    logic [3:0]         frequency_value;
  } result_t;

endpackage

@@ hdl/knob_pickup_parameter_controller.sv @@
// Top level: knob pickup state, parameter mapping and frequency debounce.
// Each accepted request pushes its result snapshot into the output buffer.
// Throughput: one request per cycle while the buffer is not full; the
// two-entry output buffer lets one result wait while the next request is taken.
// Reset (synchronous): all parameters, index, lock, ring and ring position
// clear to zero; the threshold returns to 16.
`timescale 1ns / 1ps
module knob_pickup_parameter_controller #(
  parameter int DEBOUNCE_DEPTH = kppc_pkg::KPPC_DEBOUNCE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  selected_control,
  output logic        is_locked,
  output logic [6:0]  tuning_value,
  output logic [1:0]  oscillator_wave,
  output logic [1:0]  lfo_wave,
  output logic [6:0]  lfo_rate,
  output logic [10:0] attack_time,
  output logic [10:0] decay_time,
  output logic [3:0]  frequency_value,
  input  logic        cfg_write_enable,
  input  logic [9:0]  cfg_write_data
);
  import kppc_pkg::*;

  localparam int POS_W = $clog2(DEBOUNCE_DEPTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEBOUNCE_DEPTH - 1);

  logic [SAMPLE_W-1:0] unlock_threshold;
  logic [INDEX_W-1:0]  current_index, current_index_next;
  logic                lock_flag, lock_flag_next;
  logic [SAMPLE_W-1:0] previous_sample, previous_sample_next;
  logic [6:0]          tuning_reg, tuning_reg_next;
  logic [1:0]          osc_wave_reg, osc_wave_reg_next;
  logic [1:0]          lfo_wave_reg, lfo_wave_reg_next;
  logic [6:0]          lfo_rate_reg, lfo_rate_reg_next;
  logic [10:0]         attack_reg, attack_reg_next;
  logic [10:0]         decay_reg, decay_reg_next;
  logic [3:0]          freq_reg, freq_reg_next;
  logic [SAMPLE_W-1:0] debounce_ring [DEBOUNCE_DEPTH];
  logic [POS_W-1:0]    ring_position, ring_position_next;
  logic                ring_write;

  logic                accept;
  logic                buf_full;
  logic signed [11:0]  sv_s, win_lo, win_hi;
  logic                knob_hold, freq_taken, ring_same;
  logic [POS_W-1:0]    pos_inc;
  result_t             result, out_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = !buf_full;

  // pickup window, signed
  assign sv_s   = signed'({2'b00, sample_value});
  assign win_lo = signed'({2'b00, previous_sample}) - signed'({2'b00, unlock_threshold});
  assign win_hi = signed'({2'b00, previous_sample}) + signed'({2'b00, unlock_threshold});
  assign knob_hold = lock_flag && ((sample_value < unlock_threshold) ||
                                   ((sv_s > win_lo) && (sv_s < win_hi)));

  assign freq_taken = (sample_value >= unlock_threshold);
  assign pos_inc    = (ring_position == POS_LAST) ? '0 : ring_position + POS_W'(1);

  always_comb begin
    ring_same = 1'b1;
    for (int j = 0; j < DEBOUNCE_DEPTH; j++) begin
      if ((POS_W'(j) != pos_inc) && (debounce_ring[j] != sample_value)) begin
        ring_same = 1'b0;
      end
    end
  end

  always_comb begin
    current_index_next   = current_index;
    lock_flag_next       = lock_flag;
    previous_sample_next = previous_sample;
    tuning_reg_next      = tuning_reg;
    osc_wave_reg_next    = osc_wave_reg;
    lfo_wave_reg_next    = lfo_wave_reg;
    lfo_rate_reg_next    = lfo_rate_reg;
    attack_reg_next      = attack_reg;
    decay_reg_next       = decay_reg;
    freq_reg_next        = freq_reg;
    ring_position_next   = ring_position;
    ring_write           = 1'b0;
    unique case (command_t'(command))
      CMD_KNOB: begin
        if (!knob_hold) begin
          lock_flag_next       = 1'b0;
          previous_sample_next = sample_value;
          unique case (current_index)
            CTRL_TUNING:   tuning_reg_next   = sample_value[9:3];
            CTRL_OSC_WAVE: osc_wave_reg_next = sample_value[9:8];
            CTRL_LFO_WAVE: lfo_wave_reg_next = sample_value[9:8];
            CTRL_LFO_RATE: lfo_rate_reg_next = {1'b0, sample_value[9:4]} + 7'd1;
            CTRL_ATTACK:   attack_reg_next   = {1'b0, sample_value} + 11'd1;
            CTRL_DECAY:    decay_reg_next    = {1'b0, sample_value} + 11'd1;
            default: ;
          endcase
        end
      end
      CMD_NEXT: begin
        lock_flag_next     = 1'b1;
        current_index_next = (current_index == CONTROL_LAST) ? '0
                                                             : current_index + INDEX_W'(1);
      end
      CMD_LOCK: begin
        lock_flag_next       = 1'b1;
        previous_sample_next = sample_value;
      end
      CMD_FREQ: begin
        if (freq_taken) begin
          ring_write         = 1'b1;
          ring_position_next = pos_inc;
          if (ring_same) begin
            freq_reg_next = sample_value[9:6];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_threshold <= SAMPLE_W'(16);
      current_index    <= '0;
      lock_flag        <= 1'b0;
      previous_sample  <= '0;
      tuning_reg       <= '0;
      osc_wave_reg     <= '0;
      lfo_wave_reg     <= '0;
      lfo_rate_reg     <= '0;
      attack_reg       <= '0;
      decay_reg        <= '0;
      freq_reg         <= '0;
      ring_position    <= '0;
      for (int j = 0; j < DEBOUNCE_DEPTH; j++) begin
        debounce_ring[j] <= '0;
      end
    end else begin
      if (cfg_write_enable) begin
        unlock_threshold <= cfg_write_data;
      end
      if (accept) begin
        current_index   <= current_index_next;
        lock_flag       <= lock_flag_next;
        previous_sample <= previous_sample_next;
        tuning_reg      <= tuning_reg_next;
        osc_wave_reg    <= osc_wave_reg_next;
        lfo_wave_reg    <= lfo_wave_reg_next;
        lfo_rate_reg    <= lfo_rate_reg_next;
        attack_reg      <= attack_reg_next;
        decay_reg       <= decay_reg_next;
        freq_reg        <= freq_reg_next;
        ring_position   <= ring_position_next;
        if (ring_write) begin
          debounce_ring[pos_inc] <= sample_value;
        end
      end
    end
  end

  // snapshot of the state after this request
  always_comb begin
    result.selected_control = current_index_next;
    result.is_locked        = lock_flag_next;
    result.tuning_value     = tuning_reg_next;
    result.oscillator_wave  = osc_wave_reg_next;
    result.lfo_wave         = lfo_wave_reg_next;
    result.lfo_rate         = lfo_rate_reg_next;
    result.attack_time      = attack_reg_next;
    result.decay_time       = decay_reg_next;
    result.frequency_value  = freq_reg_next;
  end

  kppc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign selected_control = out_data.selected_control;
  assign is_locked        = out_data.is_locked;
  assign tuning_value     = out_data.tuning_value;
  assign oscillator_wave  = out_data.oscillator_wave;
  assign lfo_wave         = out_data.lfo_wave;
  assign lfo_rate         = out_data.lfo_rate;
  assign attack_time      = out_data.attack_time;
  assign decay_time       = out_data.decay_time;
  assign frequency_value  = out_data.frequency_value;

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    current_index <= CONTROL_LAST)
    else $error("selected index out of range");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_next_locks: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_NEXT)) |=> lock_flag)
    else $error("next control did not lock the knob");

endmodule

@@ hdl/kppc_skid.sv @@
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
module kppc_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kppc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output kppc_pkg::result_t out_data
);
  import kppc_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

@@ tb/knob_pickup_parameter_controller_checker.sv @@
// Checker: predicts the parameter snapshot for every request and compares each result.
`timescale 1ns / 1ps
module knob_pickup_parameter_controller_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  sample_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  selected_control,
  input  logic        is_locked,
  input  logic [6:0]  tuning_value,
  input  logic [1:0]  oscillator_wave,
  input  logic [1:0]  lfo_wave,
  input  logic [6:0]  lfo_rate,
  input  logic [10:0] attack_time,
  input  logic [10:0] decay_time,
  input  logic [3:0]  frequency_value,
  input  logic        cfg_write_enable,
  input  logic [9:0]  cfg_write_data,
  output int          failures,
  output int          outstanding
);
  import kppc_pkg::*;

  localparam int RING_DEPTH = KPPC_DEBOUNCE_DEPTH;

  logic [9:0] threshold = 10'd16;
  logic [9:0] last_taken = '0;
  logic [9:0] freq_ring [RING_DEPTH];
  int         ring_slot = 0;
  result_t    held = '0;
  result_t    snapshots [$];
  int         fail_tally = 0;
  int         pending_tally = 0;

  assign failures = fail_tally;
  assign outstanding = pending_tally;

  task automatic clear_state();
    held = '0;
    last_taken = '0;
    threshold = 10'd16;
    ring_slot = 0;
    foreach (freq_ring[i]) freq_ring[i] = '0;
    snapshots.delete();
  endtask

  task automatic map_knob(logic [9:0] v);
    case (held.selected_control)
      CTRL_TUNING: held.tuning_value = v[9:3];
      CTRL_OSC_WAVE: held.oscillator_wave = v[9:8];
      CTRL_LFO_WAVE: held.lfo_wave = v[9:8];
      CTRL_LFO_RATE: held.lfo_rate = 7'(v >> 4) + 7'd1;
      CTRL_ATTACK: held.attack_time = {1'b0, v} + 11'd1;
      CTRL_DECAY: held.decay_time = {1'b0, v} + 11'd1;
      default: ;
    endcase
  endtask

  task automatic apply_request(command_t cmd, logic [9:0] v);
    int sv;
    int pv;
    int th;
    logic all_same;
    sv = v;
    pv = last_taken;
    th = threshold;
    case (cmd)
      CMD_KNOB: begin
        // pickup window is open on both sides and compared signed
        if (!held.is_locked || !(sv < th || (sv > pv - th && sv < pv + th))) begin
          held.is_locked = 1'b0;
          last_taken = v;
          map_knob(v);
        end
      end
      CMD_NEXT: begin
        held.is_locked = 1'b1;
        held.selected_control = (held.selected_control == CONTROL_LAST) ?
                                CTRL_TUNING : held.selected_control + 3'd1;
      end
      CMD_LOCK: begin
        held.is_locked = 1'b1;
        last_taken = v;
      end
      default: begin
        if (v >= threshold) begin
          ring_slot = (ring_slot + 1) % RING_DEPTH;
          freq_ring[ring_slot] = v;
          all_same = 1'b1;
          for (int i = 1; i < RING_DEPTH; i++)
            if (freq_ring[i] != freq_ring[i-1]) all_same = 1'b0;
          if (all_same) held.frequency_value = v[9:6];
        end
      end
    endcase
    snapshots.push_back(held);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_tally++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_state();
    end else begin
      // a request taken at this edge still sees the old threshold
      if (in_valid && in_ready) apply_request(command_t'(command), sample_value);
      if (cfg_write_enable) threshold = cfg_write_data;
      if (out_valid && out_ready) begin
        if (snapshots.size() == 0) begin
          fail_tally++;
          $error("result with no request outstanding");
        end else begin
          want = snapshots.pop_front();
          check_field("selected_control", want.selected_control, selected_control);
          check_field("is_locked", want.is_locked, is_locked);
          check_field("tuning_value", want.tuning_value, tuning_value);
          check_field("oscillator_wave", want.oscillator_wave, oscillator_wave);
          check_field("lfo_wave", want.lfo_wave, lfo_wave);
          check_field("lfo_rate", want.lfo_rate, lfo_rate);
          check_field("attack_time", want.attack_time, attack_time);
          check_field("decay_time", want.decay_time, decay_time);
          check_field("frequency_value", want.frequency_value, frequency_value);
        end
      end
    end
    pending_tally = snapshots.size();
  end

endmodule

@@ tb/knob_pickup_parameter_controller_tb.sv @@
// Testbench top: clock, reset, request and result traffic, threshold phases and verdict.
`timescale 1ns / 1ps
module knob_pickup_parameter_controller_tb;
  import kppc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = 2'(CMD_KNOB);
  logic [9:0]  sample_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  selected_control;
  logic        is_locked;
  logic [6:0]  tuning_value;
  logic [1:0]  oscillator_wave;
  logic [1:0]  lfo_wave;
  logic [6:0]  lfo_rate;
  logic [10:0] attack_time;
  logic [10:0] decay_time;
  logic [3:0]  frequency_value;
  logic        cfg_write_enable = 1'b0;
  logic [9:0]  cfg_write_data = '0;
  int          failures;
  int          outstanding;

  int cycles = 0;
  bit quiet = 1'b0;
  int aim = 0;
  int thr_now = 16;

  knob_pickup_parameter_controller uut (.*);
  knob_pickup_parameter_controller_checker watcher (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(command_t cmd, int v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sample_value <= v[9:0];
    if (cmd == CMD_KNOB || cmd == CMD_LOCK) aim = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_threshold(int v);
    drain();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v[9:0];
    thr_now = v;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic int near_edge();
    int side;
    side = $urandom_range(0, 1) ? thr_now : -thr_now;
    return clamp_sample(aim + side + $urandom_range(0, 4) - 2);
  endfunction

  task automatic random_phase(int count);
    int n;
    int v;
    int reps;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          v = $urandom_range(0, 1) ? near_edge() : $urandom_range(0, 1023);
          send_request(CMD_KNOB, v);
          n++;
        end
        4: begin
          send_request(CMD_NEXT, $urandom_range(0, 1023));
          n++;
        end
        5: begin
          send_request(CMD_LOCK, $urandom_range(0, 1023));
          n++;
        end
        6, 7, 8: begin
          // repeated readings so the debounce ring settles
          v = $urandom_range(0, 3) == 0 ? $urandom_range(0, thr_now) : $urandom_range(0, 1023);
          reps = $urandom_range(1, 6);
          repeat (reps) begin
            send_request(CMD_FREQ, $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : v);
            n++;
          end
        end
        default: begin
          send_request(CMD_KNOB, $urandom_range(0, 1023));
          n++;
        end
      endcase
    end
  endtask

  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // threshold at its reset value of 16
    send_request(CMD_KNOB, 0);
    send_request(CMD_KNOB, 1023);
    send_request(CMD_NEXT, 0);
    send_request(CMD_KNOB, 5);
    send_request(CMD_KNOB, 1023);
    send_request(CMD_KNOB, 1007);
    send_request(CMD_NEXT, 1023);
    send_request(CMD_KNOB, 1023);
    send_request(CMD_NEXT, 0);
    send_request(CMD_KNOB, 16);
    send_request(CMD_NEXT, 0);
    send_request(CMD_KNOB, 1023);
    send_request(CMD_NEXT, 0);
    send_request(CMD_LOCK, 512);
    send_request(CMD_KNOB, 520);
    send_request(CMD_KNOB, 528);
    send_request(CMD_NEXT, 0);
    send_request(CMD_FREQ, 15);
    repeat (4) send_request(CMD_FREQ, 1023);
    send_request(CMD_LOCK, 5);
    send_request(CMD_KNOB, 20);
    send_request(CMD_KNOB, 21);

    random_phase(120);
    set_threshold(0);
    random_phase(110);
    set_threshold(1023);
    random_phase(60);
    set_threshold($urandom_range(1, 1022));
    random_phase(110);
    set_threshold($urandom_range(1, 1022));
    random_phase(110);
    set_threshold($urandom_range(0, 40));
    random_phase(110);
    set_threshold(16);
    random_phase(60);

    drain();
    repeat (8) @(negedge clk);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
